[design/mi_pkg.sv]
`default_nettype none
package mi_pkg;

	localparam int unsigned MI_WIDTH  = 32;
	localparam int unsigned MI_DATA_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_R_ALIGN,
		ST_R_SUB,
		ST_INIT,
		ST_CHECK,
		ST_E_ALIGN,
		ST_E_SUB,
		ST_UPDATE,
		ST_FINISH
	} mi_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture operands, set up the reduction value % modulus
		logic align;   // shift divisor up one place
		logic sub;     // one restoring quotient bit
		logic init;    // seed the Euclid remainders and coefficients
		logic start;   // set up division of r_prev by r_cur
		logic update;  // rotate remainders and coefficients after a division
	} mi_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_zero;
		logic mod_one;
		logic align_more;
		logic k_zero;
		logic rc_zero;
	} mi_stat_t;

endpackage
`default_nettype wire

[design/mi_datapath.sv]
`default_nettype none
module mi_datapath import mi_pkg::*; #(
	parameter int unsigned WIDTH = MI_WIDTH
) (
	input  wire logic             clk,
	input  wire logic [WIDTH-1:0] val_in,
	input  wire logic [WIDTH-1:0] mod_in,
	input  wire mi_cmd_t          cmd,
	output mi_stat_t              stat,
	output logic      [WIDTH-1:0] res_inverse,
	output logic                  res_status
);

	localparam int unsigned KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] rp_q, rc_q;  // r_prev, r_cur
	logic [WIDTH-1:0] cp_q, cc_q;  // coefficient magnitudes
	logic             odd_q;       // parity of step count
	logic [WIDTH-1:0] rem_q;       // working dividend / remainder
	logic [WIDTH-1:0] dv_q;        // shifted divisor
	logic [KW-1:0]    k_q;         // shift position of dv_q
	logic [WIDTH-1:0] prod_q;      // quotient times cc_q, built MSB first

	logic             ge;
	logic [WIDTH-1:0] prod_add;

	assign ge       = (rem_q >= dv_q);
	assign prod_add = ge ? cc_q : '0;

	assign stat.mod_zero   = (mod_q == '0);
	assign stat.mod_one    = (mod_q == WIDTH'(1));
	assign stat.align_more = ({1'b0, rem_q} >= {dv_q, 1'b0});
	assign stat.k_zero     = (k_q == '0);
	assign stat.rc_zero    = (rc_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q  <= mod_in;
			rem_q  <= val_in;
			dv_q   <= mod_in;
			k_q    <= '0;
			prod_q <= '0;
		end else if (cmd.start) begin
			rem_q  <= rp_q;
			dv_q   <= rc_q;
			k_q    <= '0;
			prod_q <= '0;
		end else if (cmd.align) begin
			dv_q <= {dv_q[WIDTH-2:0], 1'b0};
			k_q  <= k_q + KW'(1);
		end else if (cmd.sub) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			prod_q <= {prod_q[WIDTH-2:0], 1'b0} + prod_add;
			if (k_q != '0) begin
				dv_q <= {1'b0, dv_q[WIDTH-1:1]};
				k_q  <= k_q - KW'(1);
			end
		end

		if (cmd.init) begin
			rp_q  <= mod_q;
			rc_q  <= rem_q;
			cp_q  <= '0;
			cc_q  <= WIDTH'(1);
			odd_q <= 1'b0;
		end else if (cmd.update) begin
			rp_q  <= rc_q;
			rc_q  <= rem_q;
			cp_q  <= cc_q;
			cc_q  <= cp_q + prod_q;
			odd_q <= ~odd_q;
		end
	end

	// rp_q is the gcd at the end; cp_q stays below the modulus, and is at least
	// one whenever the gcd is one, so no further reduction is needed.
	always_comb begin
		if (stat.mod_zero) begin
			res_inverse = '0;
			res_status  = 1'b1;
		end else if (stat.mod_one) begin
			res_inverse = WIDTH'(1);
			res_status  = 1'b0;
		end else if (rp_q != WIDTH'(1)) begin
			res_inverse = '0;
			res_status  = 1'b1;
		end else begin
			res_inverse = odd_q ? cp_q : (mod_q - cp_q);
			res_status  = 1'b0;
		end
	end

endmodule
`default_nettype wire

[design/mi_ctrl.sv]
`default_nettype none
module mi_ctrl import mi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     out_free,
	output logic          out_load,
	input  wire mi_stat_t stat,
	output mi_cmd_t       cmd
);

	mi_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_R_ALIGN;
			end
			ST_R_ALIGN: begin
				// zero and one moduli bypass the division entirely
				if (stat.mod_zero || stat.mod_one) state_nx = ST_FINISH;
				else if (!stat.align_more)         state_nx = ST_R_SUB;
			end
			ST_R_SUB: begin
				if (stat.k_zero) state_nx = ST_INIT;
			end
			ST_INIT: state_nx = ST_CHECK;
			ST_CHECK: begin
				state_nx = stat.rc_zero ? ST_FINISH : ST_E_ALIGN;
			end
			ST_E_ALIGN: begin
				if (!stat.align_more) state_nx = ST_E_SUB;
			end
			ST_E_SUB: begin
				if (stat.k_zero) state_nx = ST_UPDATE;
			end
			ST_UPDATE: state_nx = ST_CHECK;
			ST_FINISH: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_R_ALIGN: begin
				cmd.align = !(stat.mod_zero || stat.mod_one) && stat.align_more;
			end
			ST_R_SUB:   cmd.sub = 1'b1;
			ST_INIT:    cmd.init = 1'b1;
			ST_CHECK:   cmd.start = !stat.rc_zero;
			ST_E_ALIGN: cmd.align = stat.align_more;
			ST_E_SUB:   cmd.sub = 1'b1;
			ST_UPDATE:  cmd.update = 1'b1;
			ST_FINISH:  out_load = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

[design/modular_inverse_unit.sv]
// Modular inverse by the extended Euclidean algorithm, one item at a time.
// The value is first reduced modulo the modulus by align and subtract steps,
// then each Euclid step finds its quotient the same way; a modulus of zero
// or one skips both.
// Flow: a new item is taken only after the last one has been handed to the
// output register, and is taken while that result waits there.
// Reset: arst_n asynchronously clears the controller and output valid.
`default_nettype none
module modular_inverse_unit import mi_pkg::*; #(
	parameter int unsigned WIDTH = MI_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [MI_DATA_W-1:0] value,
	input  wire logic [MI_DATA_W-1:0] modulus,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [MI_DATA_W-1:0] inverse,
	output logic                      status
);

	mi_cmd_t          cmd;
	mi_stat_t         stat;
	logic             out_free;
	logic             out_load;
	logic [WIDTH-1:0] val_w, mod_w;
	logic [WIDTH-1:0] res_inverse;
	logic             res_status;
	logic             out_valid_q;
	logic [MI_DATA_W-1:0] inverse_q;
	logic             status_q;

	assign val_w = WIDTH'(value);
	assign mod_w = WIDTH'(modulus);

	mi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.out_load (out_load),
		.stat     (stat),
		.cmd      (cmd)
	);

	mi_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk         (clk),
		.val_in      (val_w),
		.mod_in      (mod_w),
		.cmd         (cmd),
		.stat        (stat),
		.res_inverse (res_inverse),
		.res_status  (res_status)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			inverse_q <= MI_DATA_W'(res_inverse);
			status_q  <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign inverse   = inverse_q;
	assign status    = status_q;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
	import mi_pkg::*;

	localparam logic STATUS_OK             = 1'b0;
	localparam logic STATUS_NOT_INVERTIBLE = 1'b1;

	localparam int unsigned RANDOM_ITEMS = 950;
	localparam int unsigned TAIL_CYCLES  = 400;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;

	typedef struct {
		logic [MI_DATA_W-1:0] value;
		logic [MI_DATA_W-1:0] modulus;
	} operand_pair_t;

	typedef struct {
		logic [MI_DATA_W-1:0] inverse;
		logic                 status;
	} inverse_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [MI_DATA_W-1:0] value     = '0;
	logic [MI_DATA_W-1:0] modulus   = '0;
	logic                 out_ready = 1'b0;
	wire                  in_ready;
	wire                  out_valid;
	wire  [MI_DATA_W-1:0] inverse;
	wire                  status;

	operand_pair_t   pending_operands[$];
	inverse_result_t expected_inverses[$];

	int unsigned total_items    = 0;
	int unsigned accepted_count = 0;
	int unsigned error_count    = 0;
	int unsigned cycle_count    = 0;
	int unsigned in_gap         = 0;
	int unsigned out_stall      = 0;
	logic        in_calm        = 1'b0;
	logic        out_calm       = 1'b0;

	modular_inverse_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.modulus   (modulus),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.inverse   (inverse),
		.status    (status)
	);

	// Extended Euclid tracking only coefficient magnitudes; the sign follows
	// the parity of the step count.
	function automatic inverse_result_t predict_inverse(logic [MI_DATA_W-1:0] val,
			logic [MI_DATA_W-1:0] mod);
		logic [63:0]     r_prev;
		logic [63:0]     r_cur;
		logic [63:0]     r_next;
		logic [63:0]     c_prev;
		logic [63:0]     c_cur;
		logic [63:0]     c_next;
		logic [63:0]     quo;
		logic [63:0]     mod_w;
		int unsigned     steps;
		inverse_result_t res;
		res.inverse = '0;
		res.status  = STATUS_NOT_INVERTIBLE;
		mod_w = {32'd0, mod};
		if (mod_w == 64'd0)
			return res;
		if (mod_w == 64'd1) begin
			res.inverse = 1;
			res.status  = STATUS_OK;
			return res;
		end
		r_prev = mod_w;
		r_cur  = {32'd0, val} % mod_w;
		c_prev = 64'd0;
		c_cur  = 64'd1;
		steps  = 0;
		while (r_cur != 64'd0) begin
			quo    = r_prev / r_cur;
			r_next = r_prev - quo * r_cur;
			c_next = c_prev + quo * c_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			c_prev = c_cur;
			c_cur  = c_next;
			steps++;
		end
		if (r_prev != 64'd1 || steps == 0)
			return res;
		if (steps % 2 == 1)
			res.inverse = MI_DATA_W'(c_prev % mod_w);
		else
			res.inverse = MI_DATA_W'((mod_w - (c_prev % mod_w)) % mod_w);
		res.status = STATUS_OK;
		return res;
	endfunction

	task automatic queue_operands(logic [MI_DATA_W-1:0] v, logic [MI_DATA_W-1:0] m);
		operand_pair_t p;
		p.value   = v;
		p.modulus = m;
		pending_operands.push_back(p);
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// input side: one transfer per item, random gap before the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_inverses.push_back(predict_inverse(value, modulus));
				accepted_count <= accepted_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (pending_operands.size() != 0) begin
					in_valid <= 1'b1;
					value    <= pending_operands[0].value;
					modulus  <= pending_operands[0].modulus;
					pending_operands.pop_front();
					if ($urandom_range(0, 31) == 0)
						in_calm <= !in_calm;
					in_gap <= in_calm ? 0 : $urandom_range(0, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer, then stall a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin : watch_results
			inverse_result_t want;
			int unsigned     stall;
			if (out_valid && out_ready) begin
				if (expected_inverses.size() == 0) begin
					report_mismatch($sformatf("unexpected result inverse=%0h status=%0b",
						inverse, status));
				end else begin
					want = expected_inverses.pop_front();
					if (inverse !== want.inverse)
						report_mismatch($sformatf("inverse %0h, want %0h",
							inverse, want.inverse));
					if (status !== want.status)
						report_mismatch($sformatf("status %0b, want %0b",
							status, want.status));
				end
				if ($urandom_range(0, 31) == 0)
					out_calm <= !out_calm;
				stall = out_calm ? 0 : $urandom_range(0, 16);
				if (stall == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					out_stall <= stall - 1;
				end
			end else if (out_stall != 0) begin
				out_stall <= out_stall - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin : stimulus
		logic [MI_DATA_W-1:0] v;
		logic [MI_DATA_W-1:0] m;
		int unsigned          g;

		// modulus of one and modulus of zero
		queue_operands(32'd0, 32'd1);
		queue_operands(32'hFFFF_FFFF, 32'd1);
		queue_operands(32'd0, 32'd0);
		queue_operands(32'd7, 32'd0);
		// small cases, value not below modulus, value congruent to zero
		queue_operands(32'd3, 32'd7);
		queue_operands(32'd10, 32'd7);
		queue_operands(32'd0, 32'd7);
		queue_operands(32'd14, 32'd7);
		queue_operands(32'd6, 32'd9);
		queue_operands(32'd1, 32'd2);
		queue_operands(32'd1, 32'hFFFF_FFFF);
		queue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_operands(32'h8000_0000, 32'hFFFF_FFFF);
		queue_operands(32'h8000_0000, 32'h8000_0000);
		queue_operands(32'd2, 32'd4294967291);
		queue_operands(32'hAAAA_AAAA, 32'h5555_5555);
		queue_operands(32'h5555_5555, 32'hAAAA_AAAB);
		// consecutive Fibonacci numbers: longest Euclid chain in 32 bits
		queue_operands(32'd1836311903, 32'd2971215073);
		queue_operands(32'd2971215073, 32'd1836311903);
		queue_operands(32'd1134903170, 32'd1836311903);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					v = $urandom;
					m = $urandom;
				end
				3: begin
					v = $urandom;
					m = $urandom_range(1, 64);
				end
				4: begin
					g = $urandom_range(2, 1000);
					v = g * $urandom_range(0, 4_000_000);
					m = g * $urandom_range(1, 4_000_000);
				end
				5: begin
					v = $urandom;
					m = $urandom_range(0, 1) ? 32'd4294967291 : 32'd2147483647;
				end
				6: begin
					v = $urandom;
					m = $urandom_range(2, 65535);
				end
				7: begin
					v = 32'd1 << $urandom_range(0, 31);
					m = $urandom | 32'd1;
				end
				8: begin
					m = $urandom_range(1, 32'hFFFF);
					v = m * $urandom_range(0, 65535);
				end
				default: begin
					v = $urandom;
					m = 32'd1 << $urandom_range(1, 31);
				end
			endcase
			queue_operands(v, m);
		end
		total_items = pending_operands.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_items || expected_inverses.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
design/mi_pkg.sv
design/mi_datapath.sv
design/mi_ctrl.sv
design/modular_inverse_unit.sv
tb/sv/tb.sv
